[rtl/gsfl_pkg.sv]
package gsfl_pkg;

    // sizing of the slot pool
    localparam int MAX_GROUPS  = 16;
    localparam int GROUP_SLOTS = 16;
    localparam int TOTAL_SLOTS = MAX_GROUPS * GROUP_SLOTS;

    localparam int GRP_IDX_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int SLOT_IDX_W = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
    localparam int ADDR_W     = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int CNT_W      = $clog2(TOTAL_SLOTS + 1);
    localparam int NG_W       = $clog2(MAX_GROUPS + 2);
    localparam int USED_W     = $clog2(GROUP_SLOTS + 1);

    // fixed field widths of the ports
    localparam int CMD_W      = 2;
    localparam int GROUP_W    = 5;
    localparam int SLOT_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int USED_OUT_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_FINE      = 2'd0,
        STS_EXHAUSTED = 2'd1,
        STS_INVALID   = 2'd2,
        STS_NOT_USED  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_OPEN,
        S_POP,
        S_POP_WAIT,
        S_LOOK,
        S_CHECK,
        S_RESP
    } t_state;

    // one free-stack entry: zero-based group and slot
    typedef struct packed {
        logic [GRP_IDX_W-1:0]  grp_idx;
        logic [SLOT_IDX_W-1:0] slot_idx;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic set_exhaust;
        logic set_invalid;
        logic open_push;
        logic pop_issue;
        logic pop_finish;
        logic look_issue;
        logic look_finish;
        logic resp_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic stack_empty;
        logic groups_left;
        logic slot_valid;
        logic open_last;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/gsfl_ctrl.sv]
module gsfl_ctrl
    import gsfl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.cmd == CMD_ALLOC) begin
                    if (!i_stat.stack_empty) n_state = S_POP;
                    else if (i_stat.groups_left) n_state = S_OPEN;
                    else n_state = S_RESP;
                end else if (i_stat.cmd == CMD_NONE || !i_stat.slot_valid) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_LOOK;
                end
            end
            S_OPEN: begin
                if (i_stat.open_last) n_state = S_POP;
            end
            S_POP:      n_state = S_POP_WAIT;
            S_POP_WAIT: n_state = S_RESP;
            S_LOOK:     n_state = S_CHECK;
            S_CHECK:    n_state = S_RESP;
            S_RESP: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_req = i_in_valid;
            end
            S_DECODE: begin
                if (i_stat.cmd == CMD_ALLOC) begin
                    o_cmd.set_exhaust = i_stat.stack_empty && !i_stat.groups_left;
                end else begin
                    o_cmd.set_invalid = (i_stat.cmd == CMD_NONE) || !i_stat.slot_valid;
                end
            end
            S_OPEN:     o_cmd.open_push   = 1'b1;
            S_POP:      o_cmd.pop_issue   = 1'b1;
            S_POP_WAIT: o_cmd.pop_finish  = 1'b1;
            S_LOOK:     o_cmd.look_issue  = 1'b1;
            S_CHECK:    o_cmd.look_finish = 1'b1;
            S_RESP:     o_cmd.resp_load   = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

[rtl/gsfl_dp.sv]
module gsfl_dp
    import gsfl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [GROUP_W-1:0]    i_group,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic                  i_out_ready,
    input  t_dp_cmd               i_dp_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    output logic                  o_ok,
    output logic [STATUS_W-1:0]   o_status,
    output logic [GROUP_W-1:0]    o_out_group,
    output logic [SLOT_W-1:0]     o_out_slot,
    output logic [USED_OUT_W-1:0] o_group_used
);

    function automatic logic [ADDR_W-1:0] slot_addr(
        input logic [GRP_IDX_W-1:0]  grp_idx,
        input logic [SLOT_IDX_W-1:0] slot_idx
    );
        return ADDR_W'(int'(grp_idx) * GROUP_SLOTS + int'(slot_idx));
    endfunction

    // request registers
    t_cmd               r_cmd;
    logic [GROUP_W-1:0] r_grp_in;
    logic [SLOT_W-1:0]  r_slot_in;

    // allocator state
    logic [CNT_W-1:0]      r_free_count;
    logic [NG_W-1:0]       r_next_group;
    logic [SLOT_IDX_W-1:0] r_open_cnt;
    logic [USED_W-1:0]     r_used [MAX_GROUPS];

    // memories and their registered read data
    t_entry r_stack_mem [TOTAL_SLOTS];
    logic   r_use_mem   [TOTAL_SLOTS];
    t_entry r_stk_rd;
    logic   r_use_rd;

    // result and output registers
    logic                  r_res_ok;
    t_status               r_res_sts;
    logic [GROUP_W-1:0]    r_res_grp;
    logic [SLOT_W-1:0]     r_res_slot;
    logic [USED_OUT_W-1:0] r_res_used;
    logic                  r_o_valid;
    logic                  r_o_ok;
    t_status               r_o_sts;
    logic [GROUP_W-1:0]    r_o_grp;
    logic [SLOT_W-1:0]     r_o_slot;
    logic [USED_OUT_W-1:0] r_o_used;

    logic [GRP_IDX_W-1:0]  req_grp_idx;
    logic [SLOT_IDX_W-1:0] req_slot_idx;
    logic [ADDR_W-1:0]     req_addr;
    logic [GRP_IDX_W-1:0]  ng_idx;
    logic [USED_W-1:0]     used_req;
    logic [USED_W-1:0]     used_pop;
    logic                  slot_valid;
    logic                  free_hit;
    logic                  stack_room;

    logic              stk_we;
    logic [ADDR_W-1:0] stk_waddr;
    t_entry            stk_wdata;
    logic [ADDR_W-1:0] stk_raddr;
    logic              use_we;
    logic [ADDR_W-1:0] use_waddr;

    // request decode
    assign req_grp_idx  = GRP_IDX_W'(r_grp_in - GROUP_W'(1));
    assign req_slot_idx = SLOT_IDX_W'(r_slot_in);
    assign req_addr     = slot_addr(req_grp_idx, req_slot_idx);
    assign ng_idx       = GRP_IDX_W'(r_next_group - NG_W'(1));
    assign used_req     = r_used[req_grp_idx];
    assign used_pop     = r_used[r_stk_rd.grp_idx];
    assign slot_valid   = (r_grp_in != '0) && (int'(r_grp_in) < int'(r_next_group)) &&
                          (int'(r_grp_in) <= MAX_GROUPS) && (int'(r_slot_in) < GROUP_SLOTS);
    assign free_hit     = (r_cmd == CMD_FREE) && r_use_rd;
    assign stack_room   = int'(r_free_count) < TOTAL_SLOTS;

    // status to controller
    assign o_stat.cmd         = r_cmd;
    assign o_stat.stack_empty = (r_free_count == '0);
    assign o_stat.groups_left = int'(r_next_group) <= MAX_GROUPS;
    assign o_stat.slot_valid  = slot_valid;
    assign o_stat.open_last   = int'(r_open_cnt) == GROUP_SLOTS - 1;
    assign o_stat.out_free    = !r_o_valid || i_out_ready;

    // memory port selection
    always_comb begin
        stk_we    = i_dp_cmd.open_push || (i_dp_cmd.look_finish && free_hit && stack_room);
        stk_waddr = ADDR_W'(r_free_count);
        stk_raddr = ADDR_W'(r_free_count - CNT_W'(1));
        if (i_dp_cmd.open_push) begin
            stk_wdata = '{grp_idx: ng_idx, slot_idx: r_open_cnt};
        end else begin
            stk_wdata = '{grp_idx: req_grp_idx, slot_idx: req_slot_idx};
        end
        use_we = i_dp_cmd.open_push || i_dp_cmd.pop_finish ||
                 (i_dp_cmd.look_finish && free_hit);
        if (i_dp_cmd.open_push) begin
            use_waddr = slot_addr(ng_idx, r_open_cnt);
        end else if (i_dp_cmd.pop_finish) begin
            use_waddr = slot_addr(r_stk_rd.grp_idx, r_stk_rd.slot_idx);
        end else begin
            use_waddr = req_addr;
        end
    end

    // free stack memory
    always_ff @(posedge i_clk) begin
        if (stk_we) r_stack_mem[stk_waddr] <= stk_wdata;
        if (i_dp_cmd.pop_issue) r_stk_rd <= r_stack_mem[stk_raddr];
    end

    // in-use bitmap, cleared group by group when a group is opened
    always_ff @(posedge i_clk) begin
        if (use_we) r_use_mem[use_waddr] <= i_dp_cmd.pop_finish;
        if (i_dp_cmd.look_issue) r_use_rd <= r_use_mem[req_addr];
    end

    // counters and per-group used counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_count <= '0;
            r_next_group <= NG_W'(1);
            r_open_cnt   <= '0;
            for (int i = 0; i < MAX_GROUPS; i++) r_used[i] <= '0;
        end else begin
            if (i_dp_cmd.open_push) begin
                r_free_count <= r_free_count + CNT_W'(1);
                if (o_stat.open_last) begin
                    r_open_cnt   <= '0;
                    r_next_group <= r_next_group + NG_W'(1);
                end else begin
                    r_open_cnt <= r_open_cnt + SLOT_IDX_W'(1);
                end
            end
            if (i_dp_cmd.pop_issue) r_free_count <= r_free_count - CNT_W'(1);
            if (i_dp_cmd.pop_finish) r_used[r_stk_rd.grp_idx] <= used_pop + USED_W'(1);
            if (i_dp_cmd.look_finish && free_hit) begin
                if (stack_room) r_free_count <= r_free_count + CNT_W'(1);
                if (used_req != '0) r_used[req_grp_idx] <= used_req - USED_W'(1);
            end
        end
    end

    // request capture and result formation
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load_req) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_grp_in  <= i_group;
            r_slot_in <= i_slot;
        end
        if (i_dp_cmd.set_exhaust || i_dp_cmd.set_invalid) begin
            r_res_ok   <= 1'b0;
            r_res_sts  <= i_dp_cmd.set_exhaust ? STS_EXHAUSTED : STS_INVALID;
            r_res_grp  <= '0;
            r_res_slot <= '0;
            r_res_used <= '0;
        end
        if (i_dp_cmd.pop_finish) begin
            r_res_ok   <= 1'b1;
            r_res_sts  <= STS_FINE;
            r_res_grp  <= GROUP_W'(int'(r_stk_rd.grp_idx) + 1);
            r_res_slot <= SLOT_W'(r_stk_rd.slot_idx);
            r_res_used <= USED_OUT_W'(int'(used_pop) + 1);
        end
        if (i_dp_cmd.look_finish) begin
            r_res_grp  <= '0;
            r_res_slot <= '0;
            if (!r_use_rd) begin
                r_res_ok   <= 1'b0;
                r_res_sts  <= STS_NOT_USED;
                r_res_used <= USED_OUT_W'(used_req);
            end else if (r_cmd == CMD_CHECK) begin
                r_res_ok   <= 1'b1;
                r_res_sts  <= STS_FINE;
                r_res_used <= USED_OUT_W'(used_req);
            end else begin
                r_res_ok   <= 1'b1;
                r_res_sts  <= STS_FINE;
                r_res_used <= (used_req != '0) ? USED_OUT_W'(used_req - USED_W'(1)) : '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_dp_cmd.resp_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.resp_load) begin
            r_o_ok   <= r_res_ok;
            r_o_sts  <= r_res_sts;
            r_o_grp  <= r_res_grp;
            r_o_slot <= r_res_slot;
            r_o_used <= r_res_used;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_ok         = r_o_ok;
    assign o_status     = r_o_sts;
    assign o_out_group  = r_o_grp;
    assign o_out_slot   = r_o_slot;
    assign o_group_used = r_o_used;

    // free stack never holds more than the pool
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_free_count) <= TOTAL_SLOTS)
        else $error("free count beyond pool size");

    // group counter stops one past the last group
    a_group_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_next_group) <= MAX_GROUPS + 1)
        else $error("next group beyond last group");

    // opening a group only happens with room on the stack
    a_open_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.open_push |-> stack_room)
        else $error("group opened with full stack");

    // a successful result always carries the fine status
    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ok) |-> (o_status == STS_FINE))
        else $error("ok result with error status");

    // an allocated group number only comes with success
    a_alloc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_group != '0) |-> o_ok)
        else $error("group reported on failed request");

endmodule

[rtl/grouped_slot_free_list_allocator.sv]
// Grouped slot allocator: hands out slots from a LIFO free stack, frees them
// back and answers whether a slot is in use.
// Request channel: i_in_valid / o_in_ready with i_cmd, i_group, i_slot.
// Result channel: o_out_valid / i_out_ready with o_ok, o_status, o_out_group,
// o_out_slot, o_group_used; exactly one result per request, in order.
// One request is worked on at a time. Allocate from a non-empty stack, free
// and check pass from accept through decode, memory read issue, registered
// read and update, and result load before the next accept. An allocate that
// opens a new group first pushes its GROUP_SLOTS slots, one stack push per
// cycle. Rejected requests (groups exhausted, invalid slot, unused command)
// go from decode straight to result load. These steps follow from the free
// stack and in-use bitmap memories with registered reads.
// Reset (synchronous, active low) empties the stack, clears the per-group
// used counts and restarts at group 1; there is no clearing pass, since the
// in-use bits of a group are cleared while that group is opened.
// When the receiver stalls, the result waits in the output register; the
// next request is taken only once the previous result has moved into it.
module grouped_slot_free_list_allocator
    import gsfl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [GROUP_W-1:0]    i_group,
    input  logic [SLOT_W-1:0]     i_slot,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_ok,
    output logic [STATUS_W-1:0]   o_status,
    output logic [GROUP_W-1:0]    o_out_group,
    output logic [SLOT_W-1:0]     o_out_slot,
    output logic [USED_OUT_W-1:0] o_group_used
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer
    gsfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // stack, bitmap, counters and result registers
    gsfl_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_group      (i_group),
        .i_slot       (i_slot),
        .i_out_ready  (i_out_ready),
        .i_dp_cmd     (dp_cmd),
        .o_stat       (dp_stat),
        .o_out_valid  (o_out_valid),
        .o_ok         (o_ok),
        .o_status     (o_status),
        .o_out_group  (o_out_group),
        .o_out_slot   (o_out_slot),
        .o_group_used (o_group_used)
    );

endmodule
